>>> hw/rtl/matrix_inverse_3x3_assert.svh
// assertion macros for the 3x3 matrix inverse
// expects clk and rst in the scope where the macros are used
`ifndef MATRIX_INVERSE_3X3_ASSERT_SVH
`define MATRIX_INVERSE_3X3_ASSERT_SVH

// same-cycle implication
`define MI3_AST_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("matrix_inverse_3x3 assertion failed");

// next-cycle implication
`define MI3_AST_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("matrix_inverse_3x3 assertion failed");

`endif

>>> hw/rtl/mi3_pkg.sv
// shared widths, types and index tables for the 3x3 matrix inverse
// no dependencies
package mi3_pkg;

  localparam int DW         = 32;
  localparam int FRAC_BITS  = 16;
  localparam int CW         = 2 * DW;
  localparam int DETW       = 3 * DW + 1;
  localparam int QW         = DW;
  localparam int RW         = DETW + QW - 1;
  localparam int NUM_SHIFT  = 2 * FRAC_BITS;
  localparam int DIV_STAGES = QW;
  localparam int NLANE      = 9;
  localparam int FRONT_STAGES = 7;
  localparam int CORE_STAGES  = FRONT_STAGES + DIV_STAGES;

  typedef logic signed [DW-1:0]   word_t;
  typedef logic signed [CW-1:0]   cof_t;
  typedef logic signed [CW:0]     plo_t;
  typedef logic signed [DETW-1:0] det_t;
  typedef logic [DETW-1:0]        mag_t;
  typedef logic [CW-1:0]          cmag_t;
  typedef logic [RW-1:0]          rem_t;
  typedef logic [QW-1:0]          quo_t;
  typedef logic [3:0]             idx_t;

  typedef struct packed {
    logic             sing;
    logic [NLANE-1:0] neg;
  } tag_t;

  localparam word_t SAT_POS = word_t'({1'b0, {(DW-1){1'b1}}});
  localparam word_t SAT_NEG = word_t'({1'b1, {(DW-1){1'b0}}});

  // cofactor k = a[X1]*a[Y1] - a[X2]*a[Y2], entries indexed row by row
  localparam idx_t COF_X1 [NLANE] = '{4'd4, 4'd2, 4'd1, 4'd5, 4'd0, 4'd3, 4'd3, 4'd6, 4'd0};
  localparam idx_t COF_Y1 [NLANE] = '{4'd8, 4'd7, 4'd5, 4'd6, 4'd8, 4'd2, 4'd7, 4'd1, 4'd4};
  localparam idx_t COF_X2 [NLANE] = '{4'd7, 4'd1, 4'd2, 4'd3, 4'd2, 4'd0, 4'd6, 4'd0, 4'd3};
  localparam idx_t COF_Y2 [NLANE] = '{4'd5, 4'd8, 4'd4, 4'd8, 4'd6, 4'd5, 4'd4, 4'd7, 4'd1};

endpackage

>>> hw/rtl/mi3_div.sv
// pipelined restoring divider, one quotient bit per stage, nine lanes
// sharing one divisor; depends on mi3_pkg
module mi3_div import mi3_pkg::*; (
  input  logic  clk,
  input  logic  ce,
  input  mag_t  dmag_in,
  input  rem_t  num_in [NLANE],
  input  tag_t  tag_in,
  output quo_t  quo_out [NLANE],
  output tag_t  tag_out
);

  mag_t dmag_q [DIV_STAGES];
  tag_t tag_q  [DIV_STAGES];
  rem_t rem_q  [DIV_STAGES][NLANE];
  quo_t quo_q  [DIV_STAGES][NLANE];

  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
    mag_t d_src;
    tag_t t_src;
    rem_t r_src [NLANE];
    quo_t q_src [NLANE];
    rem_t shifted;

    if (s == 0) begin : g_first
      assign d_src = dmag_in;
      assign t_src = tag_in;
      assign r_src = num_in;
      assign q_src = '{default: '0};
    end else begin : g_next
      assign d_src = dmag_q[s-1];
      assign t_src = tag_q[s-1];
      assign r_src = rem_q[s-1];
      assign q_src = quo_q[s-1];
    end

    assign shifted = rem_t'(d_src) << (QW - 1 - s);

    always_ff @(posedge clk) begin
      if (ce) begin
        dmag_q[s] <= d_src;
        tag_q[s]  <= t_src;
        for (int l = 0; l < NLANE; l++) begin
          if (r_src[l] >= shifted) begin
            rem_q[s][l] <= r_src[l] - shifted;
            quo_q[s][l] <= q_src[l] | (quo_t'(1) << (QW - 1 - s));
          end else begin
            rem_q[s][l] <= r_src[l];
            quo_q[s][l] <= q_src[l];
          end
        end
      end
    end
  end

  assign quo_out = quo_q[DIV_STAGES-1];
  assign tag_out = tag_q[DIV_STAGES-1];

endmodule

>>> hw/rtl/matrix_inverse_3x3.sv
// 3x3 matrix inverse by the adjugate method, signed fixed point
// depends on mi3_pkg, mi3_div and matrix_inverse_3x3_assert.svh
//
//   channel   handshake              payload
//   request   in_valid / in_stall    a11 .. a33
//   result    out_valid / out_stall  b11 .. b33, singular
//
// one matrix per cycle sustained while the result side does not stall
// the divider has 32 stages, one quotient bit per stage
// the core pipeline stalls only when its last stage is full and the
// output register is held; until then requests keep flowing in
// reset clears valid bits only
module matrix_inverse_3x3 import mi3_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_stall,
  input  word_t a11, a12, a13, a21, a22, a23, a31, a32, a33,
  output logic  out_valid,
  input  logic  out_stall,
  output word_t b11, b12, b13, b21, b22, b23, b31, b32, b33,
  output logic  singular
);

  logic [CORE_STAGES-1:0] vld;
  logic ce, out_free;

  word_t a_q1 [NLANE];
  cof_t  p1_q2 [NLANE];
  cof_t  p2_q2 [NLANE];
  word_t row_q2 [3];
  cof_t  cof_q3 [NLANE];
  word_t row_q3 [3];
  cof_t  phi_q4 [3];
  plo_t  plo_q4 [3];
  cof_t  cof_q4 [NLANE];
  det_t  term_q5 [3];
  cof_t  cof_q5 [NLANE];
  det_t  det_q6;
  cof_t  cof_q6 [NLANE];
  mag_t  dmag_q7;
  rem_t  num_q7 [NLANE];
  tag_t  tag_q7;
  quo_t  quo_d [NLANE];
  tag_t  tag_d;
  word_t res_q [NLANE];
  logic  dneg;
  cmag_t cmag [NLANE];

  assign out_free = !out_valid || !out_stall;
  assign ce       = !vld[CORE_STAGES-1] || out_free;
  assign in_stall = !ce;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (ce) begin
      vld <= {vld[CORE_STAGES-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      a_q1 <= '{a11, a12, a13, a21, a22, a23, a31, a32, a33};
      for (int k = 0; k < NLANE; k++) begin
        p1_q2[k] <= cof_t'(a_q1[COF_X1[k]] * a_q1[COF_Y1[k]]);
        p2_q2[k] <= cof_t'(a_q1[COF_X2[k]] * a_q1[COF_Y2[k]]);
        cof_q3[k] <= p1_q2[k] - p2_q2[k];
      end
      row_q2 <= '{a_q1[0], a_q1[1], a_q1[2]};
      row_q3 <= row_q2;
      for (int j = 0; j < 3; j++) begin
        phi_q4[j]  <= cof_t'($signed(cof_q3[3*j][CW-1:DW]) * row_q3[j]);
        plo_q4[j]  <= plo_t'($signed({1'b0, cof_q3[3*j][DW-1:0]}) * row_q3[j]);
        term_q5[j] <= (det_t'(phi_q4[j]) <<< DW) + det_t'(plo_q4[j]);
      end
      cof_q4 <= cof_q3;
      cof_q5 <= cof_q4;
      cof_q6 <= cof_q5;
      det_q6 <= term_q5[0] + term_q5[1] + term_q5[2];
      dmag_q7     <= dneg ? mag_t'(-det_q6) : mag_t'(det_q6);
      tag_q7.sing <= (det_q6 == '0);
      for (int l = 0; l < NLANE; l++) begin
        num_q7[l]      <= rem_t'(cmag[l]) << NUM_SHIFT;
        tag_q7.neg[l]  <= cof_q6[l][CW-1] ^ dneg;
      end
    end
  end

  always_comb begin
    dneg = det_q6[DETW-1];
    for (int l = 0; l < NLANE; l++) begin
      cmag[l] = cof_q6[l][CW-1] ? cmag_t'(-cof_q6[l]) : cmag_t'(cof_q6[l]);
    end
  end

  mi3_div u_div (
    .clk     (clk),
    .ce      (ce),
    .dmag_in (dmag_q7),
    .num_in  (num_q7),
    .tag_in  (tag_q7),
    .quo_out (quo_d),
    .tag_out (tag_d)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= vld[CORE_STAGES-1];
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && vld[CORE_STAGES-1]) begin
      singular <= tag_d.sing;
      for (int l = 0; l < NLANE; l++) begin
        if (tag_d.sing) begin
          res_q[l] <= '0;
        end else if (tag_d.neg[l]) begin
          res_q[l] <= quo_d[l][QW-1] ? SAT_NEG : word_t'(-quo_d[l]);
        end else begin
          res_q[l] <= quo_d[l][QW-1] ? SAT_POS : word_t'(quo_d[l]);
        end
      end
    end
  end

  assign b11 = res_q[0];
  assign b12 = res_q[1];
  assign b13 = res_q[2];
  assign b21 = res_q[3];
  assign b22 = res_q[4];
  assign b23 = res_q[5];
  assign b31 = res_q[6];
  assign b32 = res_q[7];
  assign b33 = res_q[8];

`include "matrix_inverse_3x3_assert.svh"

  `MI3_AST_NXT(a_accept_enters, in_valid && !in_stall, vld[0])
  `MI3_AST_IMP(a_full_stalls, vld[CORE_STAGES-1] && out_valid && out_stall, in_stall)
  `MI3_AST_IMP(a_singular_zero, out_valid && singular,
    b11 == '0 && b12 == '0 && b13 == '0 && b21 == '0 && b22 == '0 && b23 == '0 && b31 == '0 && b32 == '0 && b33 == '0)

endmodule

>>> tb/tb_matrix_inverse_3x3.sv
// self-checking testbench for the 3x3 fixed-point matrix inverse
// holds its own exact-arithmetic predictor in a small scoreboard class
// depends on mi3_pkg and the matrix_inverse_3x3 rtl
`timescale 1ns / 100ps

module tb_matrix_inverse_3x3;
  import mi3_pkg::*;

  localparam int N_RANDOM    = 500;
  localparam int N_QUIET     = 100;
  localparam int CYCLE_LIMIT = 200000;

  typedef struct {
    word_t b[NLANE];
    logic  sing;
  } inverse_t;

  class inverse_scoreboard;
    inverse_t pending[$];
    int       errors;

    function new();
      errors = 0;
    endfunction

    function word_t quotient_entry(longint cof, logic [127:0] dmag, bit dneg);
      logic signed [127:0] cw;
      logic [127:0]        cmag, q;
      bit                  neg;
      cw   = cof;
      cmag = (cw < 0) ? -cw : cw;
      q    = (cmag << NUM_SHIFT) / dmag;
      neg  = (cof < 0) != dneg;
      if (neg) begin
        if (q >= 128'h8000_0000) return SAT_NEG;
        return word_t'(32'd0 - q[31:0]);
      end
      if (q > 128'h7FFF_FFFF) return SAT_POS;
      return word_t'(q[31:0]);
    endfunction

    function void note_request(word_t a[NLANE]);
      longint              c[NLANE];
      logic signed [127:0] d, e0, e1, e2, c0, c3, c6;
      logic [127:0]        dmag;
      inverse_t            r;
      for (int k = 0; k < NLANE; k++)
        c[k] = longint'(a[COF_X1[k]]) * longint'(a[COF_Y1[k]])
             - longint'(a[COF_X2[k]]) * longint'(a[COF_Y2[k]]);
      e0 = a[0]; e1 = a[1]; e2 = a[2];
      c0 = c[0]; c3 = c[3]; c6 = c[6];
      d  = e0 * c0 + e1 * c3 + e2 * c6;
      if (d == 0) begin
        foreach (r.b[k]) r.b[k] = '0;
        r.sing = 1'b1;
      end else begin
        dmag = (d < 0) ? -d : d;
        foreach (r.b[k]) r.b[k] = quotient_entry(c[k], dmag, d < 0);
        r.sing = 1'b0;
      end
      pending.insert(pending.size(), r);
    endfunction

    function void check_result(inverse_t got);
      inverse_t want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual singular=%0b", $time,
                 got.sing);
        errors++;
        return;
      end
      want = pending.pop_front();
      for (int k = 0; k < NLANE; k++)
        if (got.b[k] !== want.b[k]) begin
          $display("%0t: entry %0d mismatch, expected %h, actual %h", $time, k,
                   want.b[k], got.b[k]);
          errors++;
        end
      if (got.sing !== want.sing) begin
        $display("%0t: singular mismatch, expected %0b, actual %0b", $time,
                 want.sing, got.sing);
        errors++;
      end
    endfunction
  endclass

  logic  clk = 1'b0;
  logic  rst = 1'b1;
  logic  in_valid = 1'b0;
  logic  in_stall;
  logic  out_valid;
  logic  out_stall = 1'b0;
  logic  singular;
  word_t req[NLANE];
  word_t b11, b12, b13, b21, b22, b23, b31, b32, b33;
  bit    quiet = 1'b0;
  bit    done = 1'b0;
  int    cycles = 0;
  inverse_scoreboard sb = new();

  initial foreach (req[k]) req[k] = '0;

  matrix_inverse_3x3 dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .a11(req[0]), .a12(req[1]), .a13(req[2]),
    .a21(req[3]), .a22(req[4]), .a23(req[5]),
    .a31(req[6]), .a32(req[7]), .a33(req[8]),
    .out_valid(out_valid), .out_stall(out_stall),
    .b11(b11), .b12(b12), .b13(b13), .b21(b21), .b22(b22), .b23(b23),
    .b31(b31), .b32(b32), .b33(b33), .singular(singular)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // result side: random stall bursts, checked at the rising edge
  initial begin
    int n;
    @(negedge clk);
    while (!done) begin
      if (!quiet && $urandom_range(0, 3) == 0) begin
        n = $urandom_range(1, 8);
        out_stall <= 1'b1;
        repeat (n) @(negedge clk);
        out_stall <= 1'b0;
      end
      n = $urandom_range(1, 12);
      repeat (n) @(negedge clk);
    end
  end

  always @(posedge clk) begin
    inverse_t got;
    if (!rst && out_valid && !out_stall) begin
      got.b = '{b11, b12, b13, b21, b22, b23, b31, b32, b33};
      got.sing = singular;
      sb.check_result(got);
    end
  end

  task automatic send_matrix(word_t m[NLANE]);
    int n;
    if (!quiet && $urandom_range(0, 4) == 0) begin
      n = $urandom_range(1, 8);
      in_valid <= 1'b0;
      repeat (n) @(negedge clk);
    end
    for (int k = 0; k < NLANE; k++) req[k] <= m[k];
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    sb.note_request(m);
    @(negedge clk);
  endtask

  function automatic word_t small_value();
    return word_t'($signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000);
  endfunction

  function automatic void random_matrix(output word_t m[NLANE]);
    int mode;
    mode = $urandom_range(0, 9);
    for (int k = 0; k < NLANE; k++)
      m[k] = (mode <= 2) ? word_t'($urandom) : small_value();
    case (mode)
      7: for (int k = 0; k < 3; k++) m[6 + k] = m[k];
      8: for (int k = 0; k < NLANE; k++)
           if (k % 4 != 0 && $urandom_range(0, 2) != 0) m[k] = '0;
      9: m[$urandom_range(0, 8)] = $urandom_range(0, 1) ? SAT_POS : SAT_NEG;
      default: ;
    endcase
  endfunction

  function automatic void diag(output word_t m[NLANE], input word_t x, input word_t y,
                               input word_t z);
    foreach (m[k]) m[k] = '0;
    m[0] = x; m[4] = y; m[8] = z;
  endfunction

  initial begin
    word_t m[NLANE];
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // identity, scaled and negated identities, truncation, saturation and singular cases
    diag(m, 32'sh1_0000, 32'sh1_0000, 32'sh1_0000);       send_matrix(m);
    diag(m, -32'sh1_0000, 32'sh2_0000, 32'sh3_0000);      send_matrix(m);
    diag(m, 32'sd1, 32'sd1, 32'sd1);                      send_matrix(m);
    diag(m, -32'sd1, 32'sd1, -32'sd1);                    send_matrix(m);
    diag(m, SAT_POS, SAT_POS, SAT_POS);                   send_matrix(m);
    diag(m, SAT_NEG, SAT_NEG, SAT_NEG);                   send_matrix(m);
    diag(m, SAT_NEG, SAT_POS, 32'sh1_0000);               send_matrix(m);
    diag(m, 32'sh3_0000, 32'sh7_0000, -32'sh3_0000);      send_matrix(m);
    foreach (m[k]) m[k] = '0;                             send_matrix(m);
    foreach (m[k]) m[k] = SAT_POS;                        send_matrix(m);
    foreach (m[k]) m[k] = SAT_NEG;                        send_matrix(m);
    foreach (m[k]) m[k] = -32'sd1;                        send_matrix(m);
    m = '{32'sh2_0000, 32'sh1_0000, 32'sh0, 32'sh1_0000, 32'sh3_0000, 32'sh1_0000,
          32'sh0, 32'sh1_0000, 32'sh4_0000};              send_matrix(m);
    m = '{SAT_NEG, SAT_POS, SAT_NEG, SAT_POS, SAT_NEG, SAT_NEG,
          SAT_POS, SAT_NEG, SAT_POS};                     send_matrix(m);
    m = '{32'sd1, 32'sd2, 32'sd3, 32'sd4, 32'sd5, 32'sd6, 32'sd7, 32'sd8, 32'sd10};
    send_matrix(m);
    m = '{32'sd1, 32'sd2, 32'sd3, 32'sd4, 32'sd5, 32'sd6, 32'sd7, 32'sd8, 32'sd9};
    send_matrix(m);

    for (int i = 0; i < N_RANDOM; i++) begin
      if (i == N_RANDOM - N_QUIET) quiet = 1'b1;
      random_matrix(m);
      send_matrix(m);
    end
    in_valid <= 1'b0;

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    done = 1'b1;
    if (sb.errors == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
